[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL; the enclosing scope supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/dde_pkg.sv]
`timescale 1ns / 1ps

package dde_pkg;

    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned BYTES_W     = 4;
    localparam int unsigned BSZ_W       = 7;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 80;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PASS_MODE    = 3'd0,
        REG_WIDTH_CODE   = 3'd1,
        REG_VALUE_SIGNED = 3'd2,
        REG_DELTA_BITS   = 3'd3,
        REG_VALUE_COUNT  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEQ_FIRST,
        SEQ_SECOND,
        SEQ_LATER
    } seq_t;

    typedef struct packed {
        logic        pass_mode;
        logic [1:0]  width_code;
        logic        value_signed;
        logic [6:0]  delta_bits;
        logic [31:0] value_count;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] raw;
        logic               last;
        seq_t               seq;
        logic               dd_neg;
        logic [VALUE_W-1:0] mag;
        logic               hit;
    } dd_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] data;
        logic [BYTES_W-1:0] bytes;
        logic [BSZ_W-1:0]   bsz;
        logic               berr;
    } rec_t;

    function automatic logic [VALUE_W-1:0] value_mask(input logic [1:0] wc);
        logic [VALUE_W-1:0] m;
        unique case (wc)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] value_bits(input logic [1:0] wc);
        return 7'd8 << wc;
    endfunction

    function automatic logic [BYTES_W-1:0] raw_bytes(input logic [1:0] wc);
        return 4'd1 << wc;
    endfunction

    function automatic logic [6:0] eff_bits(input logic [6:0] dbits);
        logic [6:0] e;
        if (dbits == 7'd0)
        begin
            e = 7'd1;
        end
        else if (dbits > 7'd64)
        begin
            e = 7'd64;
        end
        else
        begin
            e = dbits;
        end
        return e;
    endfunction

    function automatic logic [BSZ_W-1:0] bit_length(input logic [VALUE_W-1:0] x);
        logic [BSZ_W-1:0] n;
        n = '0;
        for (int i = 0; i < VALUE_W; i++)
        begin
            if (x[i])
            begin
                n = BSZ_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

[rtl/core/double_delta_encoder.sv]
// Path: a request accepted at s_tready is registered in the s1, s2 and s3 stages of
// dde_diff and then in the dde_outq slots before its first result shows on m_tvalid.
// Throughput: one request per cycle while each leaves at most one result and m_tready is
// high; one leaving more holds the input until all its results leave, one per cycle.
// Reset (rst_n low, asynchronous) clears the pipeline, the array tracking state and
// the configuration registers to their defaults; no clearing pass follows.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module double_delta_encoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic [dde_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dde_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [dde_pkg::VALUE_W-1:0]           s_tdata,  // value[63:0]
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // data[63:0], byte_count[67:64], bitsize_found[74:68], bounds_error[75], zero pad
    output logic [dde_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tlast
);
    import dde_pkg::*;

    cfg_t       cfg_reg;
    logic       dd_valid, dd_ready, pk_load, q_free;
    dd_item_t   dd_item;
    rec_t [2:0] pk_recs;
    logic [1:0] pk_rec_n;
    rec_t       out_rec;
    logic       first_enc_load, measure_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pass_mode    <= 1'b0;
            cfg_reg.width_code   <= 2'd3;
            cfg_reg.value_signed <= 1'b1;
            cfg_reg.delta_bits   <= 7'd64;
            cfg_reg.value_count  <= 32'd1;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_PASS_MODE:    cfg_reg.pass_mode    <= cfg_wdata[0];
                REG_WIDTH_CODE:   cfg_reg.width_code   <= cfg_wdata[1:0];
                REG_VALUE_SIGNED: cfg_reg.value_signed <= cfg_wdata[0];
                REG_DELTA_BITS:   cfg_reg.delta_bits   <= cfg_wdata[6:0];
                REG_VALUE_COUNT:  cfg_reg.value_count  <= cfg_wdata;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    dde_diff u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .in_last   (s_tlast),
        .out_valid (dd_valid),
        .out_ready (dd_ready),
        .out_item  (dd_item)
    );

    dde_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (dd_valid),
        .in_ready (dd_ready),
        .in_item  (dd_item),
        .q_free   (q_free),
        .load     (pk_load),
        .recs     (pk_recs),
        .rec_n    (pk_rec_n)
    );

    dde_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (pk_load),
        .recs      (pk_recs),
        .rec_n     (pk_rec_n),
        .free      (q_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'd0, out_rec.berr, out_rec.bsz, out_rec.bytes, out_rec.data};

    assign first_enc_load = pk_load && cfg_reg.pass_mode && (dd_item.seq == SEQ_FIRST);
    assign measure_out    = m_tvalid && !cfg_reg.pass_mode;

    `ASSERT_NEXT(a_load_shows_result, pk_load && (pk_rec_n != 2'd0), m_tvalid)
    `ASSERT_IMPLY(a_first_encode_three, first_enc_load, pk_rec_n == 2'd3)
    `ASSERT_IMPLY(a_measure_single, measure_out, m_tlast && (m_tdata[67:64] == 4'd0))

endmodule

[rtl/core/dde_diff.sv]
`timescale 1ns / 1ps

module dde_diff (
    input  logic              clk,
    input  logic              rst_n,
    input  dde_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [63:0]       in_value,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output dde_pkg::dd_item_t out_item
);
    import dde_pkg::*;

    seq_t               seen_reg, seen_next;
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [VALUE_W-1:0] s1_v_reg, s1_raw_reg;
    logic               s1_last_reg;
    seq_t               s1_seq_reg;
    logic [VALUE_W-1:0] s2_cur_reg, s2_raw_reg;
    logic               s2_last_reg;
    seq_t               s2_seq_reg;
    dd_item_t           s3_item_reg, s3_item_next;
    logic [VALUE_W-1:0] prev_value_reg, prev_value_next;
    logic [VALUE_W-1:0] held_delta_reg, held_delta_next;

    logic               accept, s1_move, s3_load;
    logic [VALUE_W-1:0] mask, raw, vext, cur, dd, ndd;
    logic               sign_bit, dd_pos, cur_pos, pd_pos;

    assign s3_load  = s2_valid_reg && (!s3_valid_reg || out_ready);
    assign s1_move  = s1_valid_reg && (!s2_valid_reg || s3_load);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

    // Extend the value to 64 bits.
    always_comb
    begin
        mask = value_mask(cfg.width_code);
        raw  = in_value & mask;
        unique case (cfg.width_code)
            2'd0:    sign_bit = raw[7];
            2'd1:    sign_bit = raw[15];
            2'd2:    sign_bit = raw[31];
            default: sign_bit = 1'b0;
        endcase
        vext = (cfg.value_signed && sign_bit) ? (raw | ~mask) : raw;
    end

    always_comb
    begin
        if (in_last)
        begin
            seen_next = SEQ_FIRST;
        end
        else if (seen_reg == SEQ_FIRST)
        begin
            seen_next = SEQ_SECOND;
        end
        else
        begin
            seen_next = SEQ_LATER;
        end
    end

    assign cur             = s1_v_reg - prev_value_reg;
    assign prev_value_next = s1_last_reg ? '0 : s1_v_reg;

    always_comb
    begin
        dd      = s2_cur_reg - held_delta_reg;
        ndd     = held_delta_reg - s2_cur_reg;
        dd_pos  = (dd != '0) && !dd[VALUE_W-1];
        cur_pos = (s2_cur_reg != '0) && !s2_cur_reg[VALUE_W-1];
        pd_pos  = (held_delta_reg != '0) && !held_delta_reg[VALUE_W-1];

        s3_item_next.raw    = s2_raw_reg;
        s3_item_next.last   = s2_last_reg;
        s3_item_next.seq    = s2_seq_reg;
        s3_item_next.dd_neg = dd[VALUE_W-1];
        s3_item_next.mag    = dd[VALUE_W-1] ? ndd : dd;
        s3_item_next.hit    = (s2_seq_reg == SEQ_LATER) &&
            ((s2_cur_reg[VALUE_W-1] && pd_pos && dd_pos) ||
             (cur_pos && held_delta_reg[VALUE_W-1] && dd[VALUE_W-1]));

        if (s2_last_reg)
        begin
            held_delta_next = '0;
        end
        else if (s2_seq_reg != SEQ_FIRST)
        begin
            held_delta_next = s2_cur_reg;
        end
        else
        begin
            held_delta_next = held_delta_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= SEQ_FIRST;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            prev_value_reg <= '0;
            held_delta_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                seen_reg <= seen_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                s2_valid_reg   <= 1'b1;
                prev_value_reg <= prev_value_next;
            end
            else if (s3_load)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s3_load)
            begin
                s3_valid_reg   <= 1'b1;
                held_delta_reg <= held_delta_next;
            end
            else if (out_ready)
            begin
                s3_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_v_reg    <= vext;
            s1_raw_reg  <= raw;
            s1_last_reg <= in_last;
            s1_seq_reg  <= seen_reg;
        end
        if (s1_move)
        begin
            s2_cur_reg  <= cur;
            s2_raw_reg  <= s1_raw_reg;
            s2_last_reg <= s1_last_reg;
            s2_seq_reg  <= s1_seq_reg;
        end
        if (s3_load)
        begin
            s3_item_reg <= s3_item_next;
        end
    end

endmodule

[rtl/core/dde_pack.sv]
`timescale 1ns / 1ps

module dde_pack (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dde_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dde_pkg::dd_item_t     in_item,
    input  logic                  q_free,
    output logic                  load,
    output dde_pkg::rec_t [2:0]   recs,
    output logic [1:0]            rec_n
);
    import dde_pkg::*;

    logic [VALUE_W-1:0] word_reg, word_next;
    logic [5:0]         pos_reg, pos_next;
    logic [VALUE_W-1:0] or_reg, or_next;
    logic               bound_reg, bound_next;

    logic [6:0]         eff, vbits, sh;
    logic               trivial, later;
    logic [64:0]        mask65, chunk;
    logic [127:0]       window;
    logic [7:0]         total;
    logic [BSZ_W-1:0]   bsz;
    logic [1:0]         cnt;

    assign in_ready = q_free;
    assign load     = in_valid && q_free;
    assign rec_n    = cnt;

    always_comb
    begin
        eff     = eff_bits(cfg.delta_bits);
        vbits   = value_bits(cfg.width_code);
        trivial = eff >= (vbits - 7'd1);
        later   = in_item.seq == SEQ_LATER;

        // Sign bit then magnitude, placed MSB-first below the fill point.
        mask65 = 65'((66'd1 << eff) - 66'd1);
        chunk  = ({1'b0, in_item.mag} & mask65) | (65'(in_item.dd_neg) << eff);
        sh     = 7'd64 + {1'b0, pos_reg} - eff;
        window = {word_reg, 64'd0} | ({63'd0, chunk} << sh);
        total  = 8'd64 - {2'b00, pos_reg} + {1'b0, eff};

        or_next    = or_reg | (later ? in_item.mag : '0);
        bound_next = bound_reg | in_item.hit;
        word_next  = word_reg;
        pos_next   = pos_reg;
        bsz        = bit_length(or_next);
        if (bsz == '0)
        begin
            bsz = BSZ_W'(1);
        end

        recs = '0;
        cnt  = 2'd0;

        if (cfg.pass_mode)
        begin
            if (in_item.seq == SEQ_FIRST)
            begin
                recs[cnt] = '{data: 64'(eff), bytes: 4'd1, bsz: '0, berr: 1'b0};
                cnt       = cnt + 2'd1;
                recs[cnt] = '{data: 64'(cfg.value_count), bytes: 4'd8, bsz: '0, berr: 1'b0};
                cnt       = cnt + 2'd1;
            end
            if (!later || trivial)
            begin
                recs[cnt] = '{data: in_item.raw, bytes: raw_bytes(cfg.width_code),
                              bsz: '0, berr: 1'b0};
                cnt       = cnt + 2'd1;
            end
            else
            begin
                if (total >= 8'd64)
                begin
                    recs[cnt] = '{data: window[127:64], bytes: 4'd8, bsz: '0, berr: 1'b0};
                    cnt       = cnt + 2'd1;
                end
                if (total[7])
                begin
                    recs[cnt] = '{data: window[63:0], bytes: 4'd8, bsz: '0, berr: 1'b0};
                    cnt       = cnt + 2'd1;
                end
                pos_next = ~total[5:0];
                if (total[7])
                begin
                    word_next = '0;
                end
                else if (total[6])
                begin
                    word_next = window[63:0];
                end
                else
                begin
                    word_next = window[127:64];
                end
            end
            // Flush a partly filled word.
            if (in_item.last && !trivial && pos_next != 6'd63)
            begin
                recs[cnt] = '{data: word_next, bytes: 4'd8, bsz: '0, berr: 1'b0};
                cnt       = cnt + 2'd1;
            end
        end
        else if (in_item.last)
        begin
            recs[cnt] = '{data: '0, bytes: '0, bsz: bsz, berr: bound_next};
            cnt       = cnt + 2'd1;
        end

        if (in_item.last)
        begin
            word_next  = '0;
            pos_next   = 6'd63;
            or_next    = '0;
            bound_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= '0;
            pos_reg   <= 6'd63;
            or_reg    <= '0;
            bound_reg <= 1'b0;
        end
        else if (load)
        begin
            word_reg  <= word_next;
            pos_reg   <= pos_next;
            or_reg    <= or_next;
            bound_reg <= bound_next;
        end
    end

endmodule

[rtl/core/dde_outq.sv]
`timescale 1ns / 1ps

module dde_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  dde_pkg::rec_t [2:0] recs,
    input  logic [1:0]          rec_n,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output dde_pkg::rec_t       out_rec,
    output logic                out_last
);
    import dde_pkg::*;

    rec_t [2:0] slot_reg;
    logic [1:0] n_reg, rd_reg, rd_next;
    logic       drain;

    assign out_valid = rd_reg != n_reg;
    assign out_last  = (rd_reg + 2'd1) == n_reg;
    assign drain     = out_valid && out_ready;
    assign free      = !out_valid || (out_last && out_ready);
    assign rd_next   = rd_reg + 2'd1;

    always_comb
    begin
        unique case (rd_reg)
            2'd0:    out_rec = slot_reg[0];
            2'd1:    out_rec = slot_reg[1];
            default: out_rec = slot_reg[2];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg  <= 2'd0;
            rd_reg <= 2'd0;
        end
        else if (load)
        begin
            n_reg  <= rec_n;
            rd_reg <= 2'd0;
        end
        else if (drain)
        begin
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= recs;
        end
    end

endmodule

[sim/tb_double_delta_encoder.sv]
`timescale 1ns / 1ps

module tb_double_delta_encoder;
    import dde_pkg::*;

    localparam int SETTLE          = 10;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 38;
    localparam int PRESSURE_PHASE  = 4;
    localparam int OPENING_ROWS    = 34;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  bytes;
        logic [6:0]  bsz;
        logic        berr;
        logic        last;
    } chunk_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        reg_idx_t    idx;
        logic [63:0] value;
        logic        last;
        logic        has_exp;
        logic [63:0] exp_data;
        logic [3:0]  exp_bytes;
        logic [6:0]  exp_bsz;
        logic        exp_berr;
    } opening_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // predictor copy of the configuration
    logic        cfg_pass = 1'b0;
    logic [1:0]  cfg_wc = 2'd3;
    logic        cfg_signed = 1'b1;
    logic [6:0]  cfg_dbits = 7'd64;
    logic [31:0] cfg_count = 32'd1;

    // predictor copy of the per-array tracking state
    logic [63:0] prev_value = '0;
    logic [63:0] held_delta = '0;
    logic [63:0] pack_word = '0;
    logic [63:0] peak_dd = '0;
    int          seen = 0;
    int          pack_pos = 63;
    logic        overflow_seen = 1'b0;

    chunk_t chunk_q[$];

    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int errors = 0;
    int items_sent = 0;
    int arrays_done = 0;
    int reports = 0;
    int chunks_checked = 0;
    int settings = 0;

    opening_row_t opening [OPENING_ROWS] = '{
        '{ROW_ITEM, REG_PASS_MODE, 64'h5, 1'b1, 1'b1, 64'h0, 4'd0, 7'd1, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h0, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h0, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h8000_0000_0000_0000, 1'b1, 1'b1,
          64'h0, 4'd0, 7'd64, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h0, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h8000_0000_0000_0000, 1'b0, 1'b0,
          64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h8000_0000_0000_0001, 1'b1, 1'b1,
          64'h0, 4'd0, 7'd63, 1'b1},
        '{ROW_ITEM, REG_PASS_MODE, 64'h0, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0,
          64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
          64'h0, 4'd0, 7'd1, 1'b1},
        '{ROW_CFG, REG_WIDTH_CODE, 64'd0, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_CFG, REG_VALUE_SIGNED, 64'd0, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h12FF, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'hA500, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'hFF, 1'b1, 1'b1, 64'h0, 4'd0, 7'd9, 1'b0},
        '{ROW_CFG, REG_VALUE_SIGNED, 64'd1, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h80, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h7F, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h80, 1'b1, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_CFG, REG_PASS_MODE, 64'd1, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_CFG, REG_DELTA_BITS, 64'd0, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_CFG, REG_VALUE_COUNT, 64'hFFFF_FFFF, 1'b0, 1'b0,
          64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h01, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h03, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h02, 1'b1, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_CFG, REG_WIDTH_CODE, 64'd3, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_CFG, REG_DELTA_BITS, 64'd127, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0,
          64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h0, 1'b0, 1'b1, 64'h0, 4'd8, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h8000_0000_0000_0000, 1'b1, 1'b1,
          64'h8000_0000_0000_0000, 4'd8, 7'd0, 1'b0},
        '{ROW_CFG, REG_WIDTH_CODE, 64'd2, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_CFG, REG_DELTA_BITS, 64'd31, 1'b0, 1'b0, 64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'hDEAD_BEEF_8000_0001, 1'b0, 1'b0,
          64'h0, 4'd0, 7'd0, 1'b0},
        '{ROW_ITEM, REG_PASS_MODE, 64'h0000_0000_7FFF_FFFF, 1'b1, 1'b0,
          64'h0, 4'd0, 7'd0, 1'b0}
    };

    double_delta_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_double_delta_encoder: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_chunk(logic [63:0] data, logic [3:0] bytes,
                                       logic [6:0] bsz, logic berr);
        chunk_q.push_back('{data, bytes, bsz, berr, 1'b0});
    endfunction

    task automatic compute_chunks(input logic [63:0] value, input logic last_in);
        int unsigned vbits;
        int unsigned eff;
        int          base;
        logic [63:0] mask;
        logic [63:0] raw;
        logic [63:0] v;
        logic [63:0] cur;
        logic [63:0] dd;
        logic [63:0] mag;
        logic [6:0]  blen;
        logic        dd_neg;
        logic        trivial;
        base = chunk_q.size();
        vbits = 8 << cfg_wc;
        mask = (vbits == 64) ? '1 : ((64'd1 << vbits) - 64'd1);
        raw = value & mask;
        v = raw;
        if (cfg_signed && vbits < 64 && raw[vbits-1])
        begin
            v = raw | ~mask;
        end
        eff = (cfg_dbits == 7'd0) ? 1 : (cfg_dbits > 7'd64) ? 64 : cfg_dbits;
        trivial = (eff >= vbits - 1);

        if (cfg_pass && seen == 0)
        begin
            push_chunk(64'(eff), 4'd1, 7'd0, 1'b0);
            push_chunk(64'(cfg_count), 4'd8, 7'd0, 1'b0);
        end

        if (seen < 2)
        begin
            if (seen == 1)
            begin
                held_delta = v - prev_value;
            end
            if (cfg_pass)
            begin
                push_chunk(raw, 4'(vbits / 8), 7'd0, 1'b0);
            end
            seen++;
        end
        else
        begin
            cur = v - prev_value;
            dd = cur - held_delta;
            dd_neg = dd[63];
            mag = dd_neg ? (64'd0 - dd) : dd;
            if ((cur[63] && held_delta != 0 && !held_delta[63] && dd != 0 && !dd[63]) ||
                (cur != 0 && !cur[63] && held_delta[63] && dd[63]))
            begin
                overflow_seen = 1'b1;
            end
            if (mag > peak_dd)
            begin
                peak_dd = mag;
            end
            if (cfg_pass && trivial)
            begin
                push_chunk(raw, 4'(vbits / 8), 7'd0, 1'b0);
            end
            else if (cfg_pass)
            begin
                // sign first, then magnitude MSB-first
                for (int k = eff; k >= 0; k--)
                begin
                    pack_word[pack_pos] = (k == eff) ? dd_neg : mag[k];
                    if (pack_pos == 0)
                    begin
                        push_chunk(pack_word, 4'd8, 7'd0, 1'b0);
                        pack_word = '0;
                        pack_pos = 63;
                    end
                    else
                    begin
                        pack_pos--;
                    end
                end
            end
            held_delta = cur;
        end
        prev_value = v;

        if (last_in)
        begin
            if (cfg_pass)
            begin
                if (!trivial && pack_pos < 63)
                begin
                    push_chunk(pack_word, 4'd8, 7'd0, 1'b0);
                end
            end
            else
            begin
                blen = 7'd1;
                for (int i = 0; i < 64; i++)
                begin
                    if (peak_dd[i])
                    begin
                        blen = 7'(i + 1);
                    end
                end
                push_chunk(64'd0, 4'd0, blen, overflow_seen);
                reports++;
            end
            prev_value = '0;
            held_delta = '0;
            seen = 0;
            pack_word = '0;
            pack_pos = 63;
            peak_dd = '0;
            overflow_seen = 1'b0;
            arrays_done++;
        end

        if (chunk_q.size() > base)
        begin
            chunk_q[$].last = 1'b1;
        end
    endtask

    task automatic send_value(input logic [63:0] value, input logic last_in);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last_in;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        compute_chunks(value, last_in);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] wdata);
        s_tvalid <= 1'b0;
        while (chunk_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= wdata;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_PASS_MODE:    cfg_pass = wdata[0];
            REG_WIDTH_CODE:   cfg_wc = wdata[1:0];
            REG_VALUE_SIGNED: cfg_signed = wdata[0];
            REG_DELTA_BITS:   cfg_dbits = wdata[6:0];
            REG_VALUE_COUNT:  cfg_count = wdata;
            default:          ;
        endcase
        settings++;
    endtask

    // sink side: random stalls plus one long hold-off on request
    initial
    begin : sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_out
        chunk_t exp_c;
        chunk_t got_c;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_c = '{m_tdata[63:0], m_tdata[67:64], m_tdata[74:68], m_tdata[75], m_tlast};
            if (chunk_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected chunk data=%h bytes=%0d bsz=%0d berr=%0d last=%0d",
                         $time, got_c.data, got_c.bytes, got_c.bsz, got_c.berr, got_c.last);
            end
            else
            begin
                exp_c = chunk_q.pop_front();
                chunks_checked++;
                if (got_c.data !== exp_c.data || got_c.bytes !== exp_c.bytes ||
                    got_c.bsz !== exp_c.bsz || got_c.berr !== exp_c.berr ||
                    got_c.last !== exp_c.last)
                begin
                    errors++;
                    $display("%0t: mismatch expected data=%h bytes=%0d bsz=%0d berr=%0d last=%0d",
                             $time, exp_c.data, exp_c.bytes, exp_c.bsz, exp_c.berr, exp_c.last);
                    $display("%0t:          actual   data=%h bytes=%0d bsz=%0d berr=%0d last=%0d",
                             $time, got_c.data, got_c.bytes, got_c.bsz, got_c.berr, got_c.last);
                end
            end
        end
    end

    initial
    begin : source
        int          sent;
        int          len;
        int          step;
        int          spread;
        int          pick;
        int unsigned vbits;
        logic        pass;
        logic [1:0]  wc;
        logic [6:0]  dbits;
        logic [31:0] count;
        logic [63:0] trend;
        logic [63:0] value;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < OPENING_ROWS; r++)
        begin
            if (opening[r].kind == ROW_CFG)
            begin
                write_reg(opening[r].idx, opening[r].value[31:0]);
            end
            else
            begin
                send_value(opening[r].value, opening[r].last);
                if (opening[r].has_exp)
                begin
                    void'(chunk_q.pop_back());
                    chunk_q.push_back('{opening[r].exp_data, opening[r].exp_bytes,
                                        opening[r].exp_bsz, opening[r].exp_berr, 1'b1});
                end
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            pass = (phase % 3 != 0);
            wc = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            vbits = 8 << wc;
            case ($urandom_range(0, 6))
                0:       dbits = 7'd0;
                1:       dbits = 7'd1;
                2:       dbits = 7'd64;
                3:       dbits = 7'd127;
                4:       dbits = 7'(vbits - 1);
                5:       dbits = 7'(vbits - 2);
                default: dbits = 7'($urandom_range(2, 20));
            endcase
            case ($urandom_range(0, 3))
                0:       count = 32'd1;
                1:       count = 32'hFFFF_FFFF;
                2:       count = 32'd0;
                default: count = $urandom;
            endcase
            write_reg(REG_PASS_MODE, 32'(pass));
            write_reg(REG_WIDTH_CODE, 32'(wc));
            write_reg(REG_VALUE_SIGNED, 32'($urandom_range(0, 1)));
            write_reg(REG_DELTA_BITS, 32'(dbits));
            write_reg(REG_VALUE_COUNT, count);

            calm = (phase == PRESSURE_PHASE) || (phase % 4 == 2);
            if (phase == PRESSURE_PHASE)
            begin
                hold_req = 1'b1;
            end

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                len = pass ? $urandom_range(1, 40) : $urandom_range(1, 10);
                if ($urandom_range(0, 9) == 0)
                begin
                    len = $urandom_range(1, 3);
                end
                trend = {$urandom, $urandom};
                step = int'($urandom_range(0, 2000)) - 1000;
                spread = 1 << $urandom_range(0, 10);
                for (int j = 0; j < len && sent < ITEMS_PER_PHASE; j++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 75)
                    begin
                        trend = trend + 64'(longint'(step +
                                int'($urandom_range(0, 2 * spread)) - spread));
                        value = trend;
                    end
                    else if (pick < 88)
                    begin
                        value = {$urandom, $urandom};
                    end
                    else
                    begin
                        case ($urandom_range(0, 3))
                            0:       value = '0;
                            1:       value = '1;
                            2:       value = 64'd1 << (vbits - 1);
                            default: value = (64'd1 << (vbits - 1)) - 64'd1;
                        endcase
                    end
                    if ($urandom_range(0, 1) == 1)
                    begin
                        value = value | ({$urandom, $urandom} << vbits);
                    end
                    send_value(value, j == len - 1);
                    sent++;
                end
            end
            calm = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (chunk_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2 * SETTLE) @(negedge clk);

        $display("%0d values in %0d closed arrays over %0d register writes",
                 items_sent, arrays_done, settings);
        $display("%0d output chunks checked, %0d of them measure reports",
                 chunks_checked, reports);
        if (errors == 0)
        begin
            $display("tb_double_delta_encoder: done, clean");
        end
        else
        begin
            $display("tb_double_delta_encoder: done, errors");
        end
        $finish;
    end

endmodule
